// ===== sv/pdb_pkg.sv =====
// Shared constants, tables and types of the point distance and bearing block.
package pdb_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 20;
  localparam int MAX_STAGES        = 32;

  // Fraction bits of the x/y datapath and width of the angle accumulator.
  localparam int FRAC_BITS = 12;
  localparam int Z_W       = 34;

  localparam int DIST_W    = 25;
  localparam int BEAR_W    = 17;
  localparam int DIST_MAX  = 33554431;
  localparam int BEAR_MAX  = 46080;
  localparam int DEG_SCALE = 92160;

  localparam logic [15:0] GAIN_HI = 16'h9B74;
  localparam logic [15:0] GAIN_LO = 16'hEDA8;

  // A quarter turn in accumulator units (2^32 units per turn).
  localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(64'sd1073741824);

  // atan(2^-i) in accumulator units, rounded to nearest.
  localparam logic [31:0] ATAN_UNITS [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Per-stage control that travels with each item's data.
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

// ===== sv/pdb_in_if.sv =====
// Input channel interface: one item is a pair of points.
interface pdb_in_if #(
  parameter int COORD_BITS = pdb_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

// ===== sv/pdb_out_if.sv =====
// Output channel interface: one item is a distance and a bearing.
interface pdb_out_if;
  logic                             valid;
  logic                             ready;
  logic        [pdb_pkg::DIST_W-1:0] distance;
  logic signed [pdb_pkg::BEAR_W-1:0] bearing_degrees;

  modport source (output valid, distance, bearing_degrees, input ready);
  modport sink   (input valid, distance, bearing_degrees, output ready);
endinterface

// ===== sv/pdb_prerot.sv =====
// Front stage: coordinate differences, zero detect and quarter-turn pre-rotation.
module pdb_prerot #(
  parameter int COORD_BITS = pdb_pkg::COORD_BITS_DEF,
  parameter int DW         = pdb_pkg::COORD_BITS_DEF + pdb_pkg::FRAC_BITS + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  pdb_in_if.sink                        points,
  output pdb_pkg::ctl_t                 ctl,
  output logic signed [DW-1:0]          x,
  output logic signed [DW-1:0]          y,
  output logic signed [pdb_pkg::Z_W-1:0] z,
  input  logic                          down_ready
);
  import pdb_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [DW-1:0]       xf;
  logic signed [DW-1:0]       yf;
  logic signed [DW-1:0]       x_next;
  logic signed [DW-1:0]       y_next;
  logic signed [Z_W-1:0]      z_next;
  logic                       zero_next;

  assign points.ready = !ctl.valid || down_ready;

  always_comb begin
    dx        = (COORD_BITS+1)'(points.second_x) - (COORD_BITS+1)'(points.first_x);
    dy        = (COORD_BITS+1)'(points.second_y) - (COORD_BITS+1)'(points.first_y);
    zero_next = (dx == '0) && (dy == '0);
    xf        = DW'(dy) <<< FRAC_BITS;
    yf        = DW'(dx) <<< FRAC_BITS;
    x_next    = xf;
    y_next    = yf;
    z_next    = '0;
    // Bring a vector in the left half plane into the right half plane.
    if (xf < 0) begin
      if (yf >= 0) begin
        x_next = yf;
        y_next = -xf;
        z_next = Z_QUARTER;
      end else begin
        x_next = -yf;
        y_next = xf;
        z_next = -Z_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (points.ready) begin
      ctl.valid <= points.valid;
      ctl.zero  <= zero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (points.ready) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule

// ===== sv/pdb_cstage.sv =====
// One registered CORDIC vectoring micro-rotation with a fixed shift.
module pdb_cstage #(
  parameter int DW    = pdb_pkg::COORD_BITS_DEF + pdb_pkg::FRAC_BITS + 3,
  parameter int SHIFT = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pdb_pkg::ctl_t                  in_ctl,
  input  logic signed [DW-1:0]           in_x,
  input  logic signed [DW-1:0]           in_y,
  input  logic signed [pdb_pkg::Z_W-1:0] in_z,
  output logic                           in_ready,
  output pdb_pkg::ctl_t                  out_ctl,
  output logic signed [DW-1:0]           out_x,
  output logic signed [DW-1:0]           out_y,
  output logic signed [pdb_pkg::Z_W-1:0] out_z,
  input  logic                           out_ready
);
  import pdb_pkg::*;

  localparam logic signed [Z_W-1:0] ANGLE = $signed({{(Z_W-32){1'b0}}, ATAN_UNITS[SHIFT]});

  logic signed [DW-1:0]  xs;
  logic signed [DW-1:0]  ys;
  logic signed [DW-1:0]  x_next;
  logic signed [DW-1:0]  y_next;
  logic signed [Z_W-1:0] z_next;

  assign in_ready = !out_ctl.valid || out_ready;

  always_comb begin
    xs = in_x >>> SHIFT;
    ys = in_y >>> SHIFT;
    // A zero residual counts as positive.
    if (!in_y[DW-1]) begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + ANGLE;
    end else begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (in_ready) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_x <= x_next;
      out_y <= y_next;
      out_z <= z_next;
    end
  end

endmodule

// ===== sv/pdb_scale.sv =====
// Back end: gain correction and angle-to-degree products, then rounding and saturation.
module pdb_scale #(
  parameter int DW = pdb_pkg::COORD_BITS_DEF + pdb_pkg::FRAC_BITS + 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pdb_pkg::ctl_t                  in_ctl,
  input  logic signed [DW-1:0]           in_x,
  input  logic signed [pdb_pkg::Z_W-1:0] in_z,
  output logic                           in_ready,
  pdb_out_if.source                      result
);
  import pdb_pkg::*;

  localparam int UW = DW - 1;
  localparam int HW = UW + 16;
  localparam int MW = UW + 17;
  localparam int PW = Z_W + 18;

  logic [UW-1:0]           ux;
  ctl_t                    a_ctl;
  logic [HW-1:0]           prod_hi;
  logic [HW-1:0]           prod_lo;
  logic signed [PW-1:0]    angle_prod;
  logic                    ready_b;
  logic [MW-1:0]           sum;
  logic [MW-1:0]           rnd;
  logic signed [PW-1:0]    deg_full;
  logic [DIST_W-1:0]       dist_next;
  logic signed [BEAR_W-1:0] bear_next;

  assign ready_b  = !result.valid || result.ready;
  assign in_ready = !a_ctl.valid || ready_b;
  assign ux       = (in_x > 0) ? in_x[UW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (in_ready) begin
      a_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      prod_hi    <= HW'(ux) * HW'(GAIN_HI);
      prod_lo    <= HW'(ux) * HW'(GAIN_LO);
      angle_prod <= PW'(in_z) * PW'(DEG_SCALE);
    end
  end

  always_comb begin
    sum = MW'(prod_hi) + MW'(prod_lo >> 16);
    rnd = (sum + (MW'(1) << (FRAC_BITS + 7))) >> (FRAC_BITS + 8);
    if (rnd > MW'(DIST_MAX)) begin
      dist_next = DIST_W'(DIST_MAX);
    end else begin
      dist_next = rnd[DIST_W-1:0];
    end
    deg_full = (angle_prod + (PW'(1) <<< 31)) >>> 32;
    if (deg_full > PW'(BEAR_MAX)) begin
      bear_next = BEAR_W'(BEAR_MAX);
    end else if (deg_full < -PW'(BEAR_MAX)) begin
      bear_next = -BEAR_W'(BEAR_MAX);
    end else begin
      bear_next = BEAR_W'(deg_full);
    end
    if (a_ctl.zero) begin
      dist_next = '0;
      bear_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ready_b) begin
      result.valid <= a_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      result.distance        <= dist_next;
      result.bearing_degrees <= bear_next;
    end
  end

endmodule

// ===== sv/point_distance_and_bearing_top.sv =====
// Top level of the point distance and bearing block: a pipelined CORDIC in vectoring mode.
//
// Each item on the points channel is a pair of points; the block returns one item on the
// result channel with the distance between them and the bearing from the first to the
// second, both with 8 fraction bits. The bearing is measured in degrees from the +y axis
// toward +x and lies in -180..+180. The pipeline takes one item in every clock cycle
// unless a stalled result side has filled every stage. An item passes these registers:
// the differences and the quarter-turn pre-rotation, one per CORDIC micro-rotation stage,
// the gain and degree multipliers, and rounding and saturation into the output register.
// Every stage has its own valid bit and takes a new item whenever it is empty or its
// successor moves, so a stalled result only backs up the stages behind it and empty
// slots in the pipe still fill while the result waits. Nothing is lost or repeated on a stall.
module point_distance_and_bearing_top #(
  parameter int COORD_BITS    = pdb_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = pdb_pkg::CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pdb_in_if.sink     points,
  pdb_out_if.source  result
);
  import pdb_pkg::*;

  // Datapath width: coordinate difference, the vector's length and CORDIC gain headroom.
  localparam int DW = COORD_BITS + FRAC_BITS + 3;

  localparam logic signed [BEAR_W-1:0] BEAR_HI = BEAR_W'(BEAR_MAX);
  localparam logic signed [BEAR_W-1:0] BEAR_LO = -BEAR_W'(BEAR_MAX);

  // Index k holds the item after k micro-rotations; index 0 is the pre-rotation output.
  ctl_t                  ctl_pipe [CORDIC_STAGES+1];
  logic signed [DW-1:0]  x_pipe   [CORDIC_STAGES+1];
  logic signed [DW-1:0]  y_pipe   [CORDIC_STAGES+1];
  logic signed [Z_W-1:0] z_pipe   [CORDIC_STAGES+1];
  logic                  rdy      [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] valid_vec;

  pdb_prerot #(
    .COORD_BITS (COORD_BITS),
    .DW         (DW)
  ) u_prerot (
    .clk        (clk),
    .rst        (rst),
    .points     (points),
    .ctl        (ctl_pipe[0]),
    .x          (x_pipe[0]),
    .y          (y_pipe[0]),
    .z          (z_pipe[0]),
    .down_ready (rdy[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    pdb_cstage #(
      .DW    (DW),
      .SHIFT (k)
    ) u_cstage (
      .clk       (clk),
      .rst       (rst),
      .in_ctl    (ctl_pipe[k]),
      .in_x      (x_pipe[k]),
      .in_y      (y_pipe[k]),
      .in_z      (z_pipe[k]),
      .in_ready  (rdy[k]),
      .out_ctl   (ctl_pipe[k+1]),
      .out_x     (x_pipe[k+1]),
      .out_y     (y_pipe[k+1]),
      .out_z     (z_pipe[k+1]),
      .out_ready (rdy[k+1])
    );
  end

  for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_valid
    assign valid_vec[k] = ctl_pipe[k].valid;
  end

  // The final residual y is not needed: only the length and the angle leave the pipe.
  pdb_scale #(
    .DW (DW)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (ctl_pipe[CORDIC_STAGES]),
    .in_x     (x_pipe[CORDIC_STAGES]),
    .in_z     (z_pipe[CORDIC_STAGES]),
    .in_ready (rdy[CORDIC_STAGES]),
    .result   (result)
  );

`ifndef SYNTHESIS
  // A zero vector leaves the front stage with no rotation and an empty accumulator.
  a_zero_front: assert property (@(posedge clk) disable iff (rst)
    ctl_pipe[0].valid && ctl_pipe[0].zero |->
      x_pipe[0] == '0 && y_pipe[0] == '0 && z_pipe[0] == '0)
    else $error("zero vector entered the CORDIC stages with nonzero data");

  // After pre-rotation the vector lies in the right half plane.
  a_right_half: assert property (@(posedge clk) disable iff (rst)
    ctl_pipe[0].valid |-> !x_pipe[0][DW-1])
    else $error("pre-rotation left a negative x");

  // The input side only stalls when every rotation stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !points.ready |-> &valid_vec)
    else $error("input stalled while the pipeline had an empty slot");

  // A delivered bearing never leaves the half-turn range.
  a_bear_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.bearing_degrees <= BEAR_HI && result.bearing_degrees >= BEAR_LO)
    else $error("bearing outside -180..180 degrees");
`endif

endmodule

// ===== tb/sv/point_distance_and_bearing_top_tb.sv =====
// Self-checking testbench for the point distance and bearing block.
`timescale 1ns / 100ps

module point_distance_and_bearing_top_tb;
  import pdb_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int STAGES = CORDIC_STAGES_DEF;
  // Cycles an item spends in the pipe, plus a margin, for the quiet wait at the end.
  localparam int PIPE_CYCLES = 3 + STAGES + 16;
  // Fixed run limit; far beyond the slowest legal run of this stimulus.
  localparam longint RUN_LIMIT_NS = 64'd6_000_000;

  // Accumulator quarter turn, output gain and rounding constants of the datapath.
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint unsigned GAIN_UPPER = 64'h9B74;
  localparam longint unsigned GAIN_LOWER = 64'hEDA8;
  localparam longint unsigned DIST_LIMIT = 64'd33554431;
  localparam longint BEAR_LIMIT = 64'sd46080;

  // atan(2^-i) with 2^32 units per full turn.
  localparam longint ARCTAN_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
  } point_pair_t;

  // One predicted result, kept with the points it came from for diagnostics.
  typedef struct {
    point_pair_t pts;
    logic [DIST_W-1:0] distance;
    logic signed [BEAR_W-1:0] bearing;
  } polar_t;

  logic clk;
  logic rst;

  pdb_in_if #(.COORD_BITS(COORD_W)) points_ch ();
  pdb_out_if result_ch ();

  point_distance_and_bearing_top #(
    .COORD_BITS(COORD_W),
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .points(points_ch),
    .result(result_ch)
  );

  // Predicted results in the order their point pairs were accepted.
  polar_t pending_polar[$];

  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles_left;
  int pairs_sent;
  int results_checked;
  int mismatch_count;

  // 12 ns clock period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Hard stop in case the pipe hangs or the handshakes never complete.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results still expected", pending_polar.size());
    $display("FAIL point_distance_and_bearing_top");
    $finish;
  end

  // Predicts distance and bearing of one point pair. The vector (dy, dx) is taken to the
  // right half plane by a quarter turn when needed, then rotated toward the x axis stage
  // by stage while the angle accumulator collects the turned angle. Shifts are floor
  // shifts on 64-bit signed values, which is what the hardware's arithmetic shifts give.
  function automatic polar_t cordic_vector_predict(point_pair_t p);
    longint dx, dy, x, y, z, t, xs, ys, deg;
    longint unsigned ux, prod_hi, prod_lo, dist_q;
    polar_t r;
    int k;
    r.pts = p;
    dx = longint'(p.second_x) - longint'(p.first_x);
    dy = longint'(p.second_y) - longint'(p.first_y);
    if (dx == 0 && dy == 0) begin
      r.distance = '0;
      r.bearing = '0;
      return r;
    end
    x = dy * 4096;
    y = dx * 4096;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x;
        x = y;
        y = -t;
        z = QUARTER_TURN;
      end else begin
        t = x;
        x = -y;
        y = t;
        z = -QUARTER_TURN;
      end
    end
    for (k = 0; k < STAGES && k < 32; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_STEP[k];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_STEP[k];
      end
    end
    // Gain correction with a 32-bit constant split in two halves, then round to Q.8.
    ux = (x > 0) ? longint'(x) : 64'd0;
    prod_hi = ux * GAIN_UPPER;
    prod_lo = ux * GAIN_LOWER;
    prod_hi = prod_hi + (prod_lo >> 16);
    dist_q = (prod_hi + (64'd1 << 19)) >> 20;
    if (dist_q > DIST_LIMIT) dist_q = DIST_LIMIT;
    // Accumulator units to degrees in Q.8, rounded half up, then clamped to +/-180.
    deg = (z * 92160 + (64'sd1 <<< 31)) >>> 32;
    if (deg > BEAR_LIMIT) deg = BEAR_LIMIT;
    if (deg < -BEAR_LIMIT) deg = -BEAR_LIMIT;
    r.distance = dist_q[DIST_W-1:0];
    r.bearing = deg[BEAR_W-1:0];
    return r;
  endfunction

  function automatic point_pair_t make_pair(int fx, int fy, int sx, int sy);
    point_pair_t p;
    p.first_x = COORD_W'(fx);
    p.first_y = COORD_W'(fy);
    p.second_x = COORD_W'(sx);
    p.second_y = COORD_W'(sy);
    return p;
  endfunction

  function automatic logic signed [COORD_W-1:0] edge_coord();
    logic signed [COORD_W-1:0] c;
    case ($urandom_range(0, 5))
      0: c = COORD_W'(-32768);
      1: c = COORD_W'(32767);
      2: c = '0;
      3: c = COORD_W'(-1);
      4: c = COORD_W'(1);
      default: c = COORD_W'($urandom);
    endcase
    return c;
  endfunction

  // Random point pair drawn from a mix of shapes: wide random, near neighbors (where the
  // low stages decide the angle), axis-aligned, close to the -y axis where the bearing
  // may overshoot 180 degrees, extreme coordinates, and coincident points.
  function automatic point_pair_t random_pair();
    point_pair_t p;
    int dx, dy;
    p.first_x = COORD_W'($urandom);
    p.first_y = COORD_W'($urandom);
    p.second_x = COORD_W'($urandom);
    p.second_y = COORD_W'($urandom);
    dx = int'($urandom_range(0, 16)) - 8;
    dy = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 9))
      4, 5: begin
        p.second_x = p.first_x + COORD_W'(dx);
        p.second_y = p.first_y + COORD_W'(dy);
      end
      6: begin
        if ($urandom_range(0, 1) == 0) p.second_x = p.first_x;
        else p.second_y = p.first_y;
      end
      7: begin
        p.first_y = COORD_W'(32767 - int'($urandom_range(0, 255)));
        p.second_y = COORD_W'(-32768 + int'($urandom_range(0, 32767)));
        p.second_x = p.first_x + COORD_W'(int'($urandom_range(0, 4)) - 2);
      end
      8: begin
        p.first_x = edge_coord();
        p.first_y = edge_coord();
        p.second_x = edge_coord();
        p.second_y = edge_coord();
      end
      9: begin
        if ($urandom_range(0, 3) == 0) begin
          p.second_x = p.first_x;
          p.second_y = p.first_y;
        end
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  task automatic report_mismatch(string what, polar_t want, logic [DIST_W-1:0] got_dist,
                                 logic signed [BEAR_W-1:0] got_bear);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t ns: %s: points (%0d,%0d)->(%0d,%0d) distance %0d/%0d bearing %0d/%0d",
               $time, what, want.pts.first_x, want.pts.first_y, want.pts.second_x,
               want.pts.second_y, got_dist, want.distance, got_bear, want.bearing);
    end
  endtask

  // Offers one point pair from the falling edge on and holds it until the block takes it.
  // Valid is left high after acceptance; the next call either replaces the item or drops
  // valid at the following falling edge, so valid is never toggled within one time step.
  task automatic send_pair(point_pair_t p);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      points_ch.valid = 1'b0;
      @(negedge clk);
    end
    points_ch.valid = 1'b1;
    points_ch.first_x = p.first_x;
    points_ch.first_y = p.first_y;
    points_ch.second_x = p.second_x;
    points_ch.second_y = p.second_y;
    do @(posedge clk); while (!points_ch.ready);
    pending_polar.push_back(cordic_vector_predict(p));
    pairs_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    points_ch.valid = 1'b0;
  endtask

  // Blocks until every predicted result has been checked.
  task automatic wait_all_results();
    stop_sending();
    while (pending_polar.size() != 0) @(posedge clk);
  endtask

  // Result side: ready changes only at the falling edge. A requested long hold-off is
  // counted down here, one cycle at a time, and overrides the random idling.
  always @(negedge clk) begin
    if (stall_cycles_left > 0) begin
      result_ch.ready = 1'b0;
      stall_cycles_left--;
    end else begin
      result_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Every result taken at a rising edge is compared with the oldest prediction.
  always @(posedge clk) begin
    polar_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_polar.size() == 0) begin
        want.pts = '0;
        want.distance = '0;
        want.bearing = '0;
        report_mismatch("unexpected result", want, result_ch.distance,
                        result_ch.bearing_degrees);
      end else begin
        want = pending_polar.pop_front();
        results_checked++;
        if (result_ch.distance !== want.distance) begin
          report_mismatch("distance mismatch", want, result_ch.distance,
                          result_ch.bearing_degrees);
        end
        if (result_ch.bearing_degrees !== want.bearing) begin
          report_mismatch("bearing mismatch", want, result_ch.distance,
                          result_ch.bearing_degrees);
        end
      end
    end
  end

  // Axes, the four quadrant corners, the longest vectors, coincident points, and pairs
  // that sit just beside the -y axis where the bearing is close to +/-180 degrees.
  task automatic test_directed();
    send_pair(make_pair(0, 0, 0, 0));
    send_pair(make_pair(-32768, 32767, -32768, 32767));
    send_pair(make_pair(0, 0, 0, 100));
    send_pair(make_pair(0, 0, 100, 0));
    send_pair(make_pair(0, 0, -100, 0));
    send_pair(make_pair(0, 0, 0, -100));
    send_pair(make_pair(0, 0, 0, -1));
    send_pair(make_pair(0, 32767, 0, -32768));
    send_pair(make_pair(0, 32767, 1, -32768));
    send_pair(make_pair(0, 32767, -1, -32768));
    send_pair(make_pair(-32768, -32768, 32767, 32767));
    send_pair(make_pair(32767, 32767, -32768, -32768));
    send_pair(make_pair(32767, -32768, -32768, 32767));
    send_pair(make_pair(-32768, 32767, 32767, -32768));
    send_pair(make_pair(-32768, 0, 32767, 0));
    send_pair(make_pair(32767, 0, -32768, 0));
    send_pair(make_pair(5, 5, 6, 6));
    send_pair(make_pair(5, 5, 4, 6));
    send_pair(make_pair(5, 5, 6, 4));
    send_pair(make_pair(5, 5, 4, 4));
    send_pair(make_pair(0, 0, 1000, 1000));
    send_pair(make_pair(-1, -1, -1, -32768));
    wait_all_results();
  endtask

  task automatic test_random_pairs(int count);
    repeat (count) send_pair(random_pair());
  endtask

  // Result side holds off for a long stretch while pairs keep coming, so the pipe fills
  // and the input must stall; nothing may be lost or repeated when it lets go.
  task automatic test_result_stall();
    @(posedge clk);
    stall_cycles_left = 400;
    test_random_pairs(120);
    wait_all_results();
  endtask

  // The sender pauses until the pipe has fully drained, then starts again from empty.
  task automatic test_drain_pause();
    test_random_pairs(40);
    wait_all_results();
    test_random_pairs(40);
    wait_all_results();
  endtask

  initial begin
    rst = 1'b1;
    points_ch.valid = 1'b0;
    points_ch.first_x = '0;
    points_ch.first_y = '0;
    points_ch.second_x = '0;
    points_ch.second_y = '0;
    result_ch.ready = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 84;
    stall_cycles_left = 0;
    pairs_sent = 0;
    results_checked = 0;
    mismatch_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Slow result side first, with a mostly busy sender.
    test_directed();
    test_random_pairs(520);
    wait_all_results();

    // Then a mostly idle sender against an eager result side.
    send_idle_pct = 84;
    recv_idle_pct = 7;
    test_random_pairs(520);
    wait_all_results();

    // Back to back in both directions, with the long stall and a full drain in between.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_result_stall();
    test_random_pairs(500);
    test_drain_pause();

    // Any stray result after the last expected one would be caught in this window.
    repeat (PIPE_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d point pairs: axes, extremes, near-180 bearings,",
             results_checked, pairs_sent);
    $display("coincident points, three idling mixes, a long result stall and a full drain.");
    if (mismatch_count == 0 && pending_polar.size() == 0) begin
      $display("PASS point_distance_and_bearing_top");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_polar.size());
      $display("FAIL point_distance_and_bearing_top");
    end
    $finish;
  end

endmodule
